[rtl/core/cluster_occupancy_map_top_assert.svh]
// assertion macros for the cluster occupancy map checker
// no dependencies; the including module supplies clk and rst
`ifndef CLUSTER_OCCUPANCY_MAP_TOP_ASSERT_SVH
`define CLUSTER_OCCUPANCY_MAP_TOP_ASSERT_SVH

// property checked at every edge, reset included
`define COM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// property checked outside reset only
`define COM_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[rtl/core/com_pkg.sv]
// shared types and constants of the cluster occupancy map
// used by the top, controller, datapath and divider modules of the block
package com_pkg;

  localparam int MAX_CELLS   = 1024;
  localparam int NUM_STATES  = 16;
  localparam int COUNT_WIDTH = 48;
  localparam int CELL_W      = 10;
  localparam int CELLS_W     = 11;
  localparam int STATE_W     = 4;
  localparam int ADDR_W      = CELL_W + STATE_W;
  localparam int DEPTH       = MAX_CELLS * NUM_STATES;
  localparam int IDX_W       = 3;
  localparam int DATA_W      = 48;

  localparam logic [STATE_W-1:0] STATE_FREE   = 4'd0;
  localparam logic [STATE_W-1:0] STATE_SYSTEM = 4'd1;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_MARK  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  localparam logic [IDX_W-1:0] REG_TOTAL      = 3'd0;
  localparam logic [IDX_W-1:0] REG_CELLS      = 3'd1;
  localparam logic [IDX_W-1:0] REG_EACH_CELL  = 3'd2;
  localparam logic [IDX_W-1:0] REG_FINAL_CELL = 3'd3;
  localparam logic [IDX_W-1:0] REG_OPPOSITE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_EACH_CLU   = 3'd5;
  localparam logic [IDX_W-1:0] REG_FINAL_CLU  = 3'd6;

  // commands from the controller
  typedef struct packed {
    logic load;
    logic clr_step;
    logic clr_zero;
    logic fill_step;
    logic div_go;
    logic n_init;
    logic n_seg;
    logic rd_to;
    logic wr_to;
    logic rd_from;
    logic wr_from;
    logic n_adv;
    logic o_mul;
    logic o_adj;
    logic o_end;
    logic o_step;
    logic r_issue;
    logic r_cmp;
    logic fin;
    logic fin_ok;
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    action_t in_action;
    logic    opp;
    logic    clr_last;
    logic    fill_last;
    logic    bad;
    logic    div_done;
    logic    n_work;
    logic    n_last;
    logic    o_more;
    logic    sel_bad;
    logic    r_last;
  } sts_t;

endpackage

[rtl/core/cluster_occupancy_map_top.sv]
// cluster occupancy map; actions are clear, fill, read and remark, the remark in
// normal or opposite order; a rejected word also ends with the result strobe.
// one word at a time; the strobe is high in the first cycle busy is low.
// the datapath has a single memory port and a bit-serial divider.
// after reset a pass over all 16384 count entries zeroes the memory, busy high.
module cluster_occupancy_map_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 action,
  input  logic [47:0]                span_start,
  input  logic [47:0]                span_length,
  input  logic [3:0]                 to_state,
  input  logic [3:0]                 from_state,
  input  logic [9:0]                 cell_select,
  output logic                       done,
  output logic [3:0]                 cell_state,
  output logic                       accepted,
  input  logic                       wr_en,
  input  logic [com_pkg::IDX_W-1:0]  wr_index,
  input  logic [com_pkg::DATA_W-1:0] wr_data
);
  import com_pkg::*;

  cmd_t cmd;
  sts_t sts;

  com_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  com_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .action(action),
    .span_start(span_start), .span_length(span_length), .to_state(to_state),
    .from_state(from_state), .cell_select(cell_select), .wr_en(wr_en),
    .wr_index(wr_index), .wr_data(wr_data), .done(done),
    .cell_state(cell_state), .accepted(accepted)
  );

endmodule

[rtl/core/com_ram.sv]
// generic single port ram with registered read
// no dependencies
module com_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read before write, read registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/com_div.sv]
// restoring divider, one quotient bit per cycle
// depends on com_pkg
module com_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [com_pkg::DATA_W-1:0]     dividend,
  input  logic [com_pkg::DATA_W-1:0]     divisor,
  output logic                           done,
  output logic [com_pkg::DATA_W-1:0]     quot,
  output logic [com_pkg::DATA_W-1:0]     remain
);
  import com_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [DATA_W:0]   shifted;
  logic              fits;

  // trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {remain, quot[DATA_W-1]};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CNT_W'(DATA_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift
  always_ff @(posedge clk) begin
    if (go) begin
      quot   <= dividend;
      remain <= '0;
      dvs    <= divisor;
    end else if (run) begin
      quot   <= {quot[DATA_W-2:0], fits};
      remain <= fits ? DATA_W'(shifted - {1'b0, dvs}) : shifted[DATA_W-1:0];
    end
  end

endmodule

[rtl/core/com_datapath.sv]
// datapath: config registers, count memory, walk counters, divider, result
// depends on com_pkg, com_ram, com_div
module com_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  com_pkg::cmd_t                 cmd,
  output com_pkg::sts_t                 sts,
  input  logic [1:0]                    action,
  input  logic [47:0]                   span_start,
  input  logic [47:0]                   span_length,
  input  logic [3:0]                    to_state,
  input  logic [3:0]                    from_state,
  input  logic [9:0]                    cell_select,
  input  logic                          wr_en,
  input  logic [com_pkg::IDX_W-1:0]     wr_index,
  input  logic [com_pkg::DATA_W-1:0]    wr_data,
  output logic                          done,
  output logic [3:0]                    cell_state,
  output logic                          accepted
);
  import com_pkg::*;

  localparam int PROD_W = DATA_W + CELLS_W;
  localparam int CNT_W  = PROD_W + 1;
  localparam int END_W  = CNT_W + 1;

  // config registers
  logic [47:0]        total_clusters;
  logic [CELLS_W-1:0] cells_in_use;
  logic [47:0]        clusters_each_cell;
  logic [47:0]        clusters_final_cell;
  logic               opposite_mode;
  logic [CELLS_W-1:0] cells_each_cluster;
  logic [CELLS_W-1:0] cells_final_cluster;

  // captured word
  action_t             act;
  logic [47:0]         start_q;
  logic [47:0]         len;
  logic [STATE_W-1:0]  to_q;
  logic [STATE_W-1:0]  from_q;
  logic [CELL_W-1:0]   sel;

  // walk state
  logic [ADDR_W-1:0]   sweep;
  logic [CELL_W-1:0]   fc;
  logic [47:0]         ncell;
  logic [47:0]         offset;
  logic [47:0]         nseg;
  logic                tail;
  logic [PROD_W-1:0]   first;
  logic [CNT_W-1:0]    ocnt;
  logic [CELLS_W-1:0]  oi;
  logic [CELLS_W-1:0]  oend;
  logic [STATE_W-1:0]  ost;
  logic [STATE_W-1:0]  rk;
  logic [COUNT_WIDTH-1:0] best;
  logic [STATE_W-1:0]  res;

  // memory port
  logic                   we;
  logic [ADDR_W-1:0]      addr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [COUNT_WIDTH-1:0] rdata;

  logic               div_done;
  logic [47:0]        quot;
  logic [47:0]        remain;

  logic [CELLS_W-1:0] cells;
  logic [CELL_W-1:0]  cells_m1;
  logic [48:0]        span_end;
  logic               ncell_mid;
  logic               ncell_in;
  logic [47:0]        room;
  logic [COUNT_WIDTH:0] sum;
  logic [END_W-1:0]   endv;

  com_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  com_div u_div (
    .clk(clk), .rst(rst), .go(cmd.div_go), .dividend(start_q),
    .divisor(clusters_each_cell), .done(div_done), .quot(quot), .remain(remain)
  );

  // effective cell count and span checks
  always_comb begin
    if (cells_in_use == '0) begin
      cells = CELLS_W'(1);
    end else if (cells_in_use > CELLS_W'(MAX_CELLS)) begin
      cells = CELLS_W'(MAX_CELLS);
    end else begin
      cells = cells_in_use;
    end
    cells_m1  = CELL_W'(cells - 1'b1);
    span_end  = {1'b0, start_q} + {1'b0, len};
    ncell_mid = ncell < 48'(cells_m1);
    ncell_in  = ncell < 48'(cells);
    if (ncell_mid) begin
      room = clusters_each_cell - offset;
    end else begin
      room = (clusters_final_cell > offset) ? clusters_final_cell - offset : '0;
    end
    sum  = {1'b0, rdata} + {1'b0, nseg};
    endv = END_W'(first) + END_W'(ocnt);
  end

  // status
  always_comb begin
    sts.in_action = action_t'(action);
    sts.opp       = opposite_mode;
    sts.clr_last  = sweep == '1;
    sts.fill_last = fc == cells_m1;
    sts.bad       = ({1'b0, to_q} >= 5'(NUM_STATES)) || ({1'b0, from_q} >= 5'(NUM_STATES))
                    || (span_end > {1'b0, total_clusters})
                    || (opposite_mode ? (cells_each_cluster == '0)
                                      : (clusters_each_cell == '0));
    sts.div_done  = div_done;
    sts.n_work    = ncell_in && (len != '0);
    sts.n_last    = tail;
    sts.o_more    = oi < oend;
    sts.sel_bad   = {1'b0, sel} >= cells;
    sts.r_last    = rk == '1;
  end

  // memory address and write data
  always_comb begin
    we    = 1'b0;
    addr  = {sel, rk};
    wdata = '0;
    if (cmd.clr_step) begin
      we    = 1'b1;
      addr  = sweep;
      wdata = COUNT_WIDTH'(!cmd.clr_zero && sweep[STATE_W-1:0] == STATE_FREE
                           && {1'b0, sweep[ADDR_W-1:STATE_W]} < cells);
    end else if (cmd.fill_step) begin
      we    = 1'b1;
      addr  = {fc, STATE_SYSTEM};
      wdata = (fc == cells_m1) ? clusters_final_cell : clusters_each_cell;
    end else if (cmd.rd_to || cmd.wr_to) begin
      we    = cmd.wr_to;
      addr  = {ncell[CELL_W-1:0], to_q};
      wdata = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
    end else if (cmd.rd_from || cmd.wr_from) begin
      we    = cmd.wr_from;
      addr  = {ncell[CELL_W-1:0], from_q};
      wdata = (rdata >= nseg) ? rdata - nseg : '0;
    end else if (cmd.o_step) begin
      we    = 1'b1;
      addr  = {oi[CELL_W-1:0], ost};
      wdata = COUNT_WIDTH'(ost == to_q);
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      total_clusters      <= '0;
      cells_in_use        <= CELLS_W'(1);
      clusters_each_cell  <= '0;
      clusters_final_cell <= '0;
      opposite_mode       <= 1'b0;
      cells_each_cluster  <= '0;
      cells_final_cluster <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_TOTAL:      total_clusters      <= wr_data;
        REG_CELLS:      cells_in_use        <= wr_data[CELLS_W-1:0];
        REG_EACH_CELL:  clusters_each_cell  <= wr_data;
        REG_FINAL_CELL: clusters_final_cell <= wr_data;
        REG_OPPOSITE:   opposite_mode       <= wr_data[0];
        REG_EACH_CLU:   cells_each_cluster  <= wr_data[CELLS_W-1:0];
        REG_FINAL_CLU:  cells_final_cluster <= wr_data[CELLS_W-1:0];
        default:        ;
      endcase
    end
  end

  // sweep counter for clearing
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      sweep <= '0;
    end else if (cmd.clr_step) begin
      sweep <= sweep + 1'b1;
    end
  end

  // captured word and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act     <= action_t'(action);
      start_q <= span_start;
      len     <= span_length;
      to_q    <= to_state;
      from_q  <= from_state;
      sel     <= cell_select;
      fc      <= '0;
      rk      <= '0;
      best    <= '0;
      res     <= '0;
    end
    if (cmd.fill_step) begin
      fc <= fc + 1'b1;
    end
    // normal order walk
    if (cmd.n_init) begin
      ncell  <= quot;
      offset <= remain;
    end
    if (cmd.n_seg) begin
      nseg <= (len < room) ? len : room;
      tail <= !ncell_mid;
    end
    if (cmd.n_adv) begin
      len    <= len - nseg;
      ncell  <= ncell + 1'b1;
      offset <= '0;
    end
    // opposite order walk
    if (cmd.o_mul) begin
      first <= PROD_W'(start_q) * PROD_W'(cells_each_cluster);
      ocnt  <= CNT_W'(PROD_W'(len) * PROD_W'(cells_each_cluster));
    end
    if (cmd.o_adj && span_end == {1'b0, total_clusters}) begin
      if (cells_final_cluster >= cells_each_cluster) begin
        ocnt <= ocnt + CNT_W'(cells_final_cluster - cells_each_cluster);
      end else if (ocnt > CNT_W'(cells_each_cluster - cells_final_cluster)) begin
        ocnt <= ocnt - CNT_W'(cells_each_cluster - cells_final_cluster);
      end else begin
        ocnt <= '0;
      end
    end
    if (cmd.o_end) begin
      oend <= (endv > END_W'(cells)) ? cells : endv[CELLS_W-1:0];
      oi   <= (first >= PROD_W'(cells)) ? cells : first[CELLS_W-1:0];
      ost  <= '0;
    end
    if (cmd.o_step) begin
      ost <= ost + 1'b1;
      if (ost == '1) begin
        oi <= oi + 1'b1;
      end
    end
    // dominant state scan
    if (cmd.r_cmp) begin
      rk <= rk + 1'b1;
      if (rk == '0 || rdata >= best) begin
        best <= rdata;
        res  <= rk;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.fin;
    end
    if (cmd.fin) begin
      accepted   <= cmd.fin_ok;
      cell_state <= (act == ACT_READ && cmd.fin_ok) ? res : '0;
    end
  end

endmodule

[rtl/core/com_ctrl.sv]
// controller state machine sequencing every action
// depends on com_pkg
module com_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  com_pkg::sts_t sts,
  output com_pkg::cmd_t cmd
);
  import com_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_CLEAR   = 19'h00002,
    S_FILL    = 19'h00004,
    S_CHECK   = 19'h00008,
    S_DIV     = 19'h00010,
    S_NSEG    = 19'h00020,
    S_RD_TO   = 19'h00040,
    S_WR_TO   = 19'h00080,
    S_RD_FROM = 19'h00100,
    S_WR_FROM = 19'h00200,
    S_ADV     = 19'h00400,
    S_OMUL    = 19'h00800,
    S_OADJ    = 19'h01000,
    S_OEND    = 19'h02000,
    S_OSTEP   = 19'h04000,
    S_RISSUE  = 19'h08000,
    S_RCMP    = 19'h10000,
    S_ACCEPT  = 19'h20000,
    S_REJECT  = 19'h40000
  } fsm_t;

  fsm_t state;
  fsm_t state_next;
  logic wipe;

  assign busy = state != S_IDLE;

  // wipe marks the clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      wipe  <= 1'b1;
    end else begin
      state <= state_next;
      if (state == S_CLEAR && sts.clr_last) begin
        wipe <= 1'b0;
      end
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (sts.in_action)
            ACT_CLEAR: state_next = S_CLEAR;
            ACT_FILL:  state_next = sts.opp ? S_ACCEPT : S_FILL;
            ACT_MARK:  state_next = S_CHECK;
            default:   state_next = S_RISSUE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.clr_zero = wipe;
        if (sts.clr_last) begin
          state_next = wipe ? S_IDLE : S_ACCEPT;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          state_next = S_ACCEPT;
        end
      end
      S_CHECK: begin
        if (sts.bad) begin
          state_next = S_REJECT;
        end else if (sts.opp) begin
          state_next = S_OMUL;
        end else begin
          cmd.div_go = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.n_init = 1'b1;
          state_next = S_NSEG;
        end
      end
      S_NSEG: begin
        cmd.n_seg  = 1'b1;
        state_next = sts.n_work ? S_RD_TO : S_ACCEPT;
      end
      S_RD_TO: begin
        cmd.rd_to  = 1'b1;
        state_next = S_WR_TO;
      end
      S_WR_TO: begin
        cmd.wr_to  = 1'b1;
        state_next = S_RD_FROM;
      end
      S_RD_FROM: begin
        cmd.rd_from = 1'b1;
        state_next  = S_WR_FROM;
      end
      S_WR_FROM: begin
        cmd.wr_from = 1'b1;
        state_next  = S_ADV;
      end
      S_ADV: begin
        cmd.n_adv  = 1'b1;
        state_next = sts.n_last ? S_ACCEPT : S_NSEG;
      end
      S_OMUL: begin
        cmd.o_mul  = 1'b1;
        state_next = S_OADJ;
      end
      S_OADJ: begin
        cmd.o_adj  = 1'b1;
        state_next = S_OEND;
      end
      S_OEND: begin
        cmd.o_end  = 1'b1;
        state_next = S_OSTEP;
      end
      S_OSTEP: begin
        if (sts.o_more) begin
          cmd.o_step = 1'b1;
        end else begin
          state_next = S_ACCEPT;
        end
      end
      S_RISSUE: begin
        if (sts.sel_bad) begin
          state_next = S_REJECT;
        end else begin
          cmd.r_issue = 1'b1;
          state_next  = S_RCMP;
        end
      end
      S_RCMP: begin
        cmd.r_cmp  = 1'b1;
        state_next = sts.r_last ? S_ACCEPT : S_RISSUE;
      end
      S_ACCEPT: begin
        cmd.fin    = 1'b1;
        cmd.fin_ok = 1'b1;
        state_next = S_IDLE;
      end
      S_REJECT: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/core/com_checker.sv]
// port level checks of the cluster occupancy map, bound to the top level
// depends on cluster_occupancy_map_top_assert.svh
`include "cluster_occupancy_map_top_assert.svh"

module com_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [3:0] cell_state,
  input logic       accepted
);

  `COM_ASSERT(busy_after_rst, rst |=> busy, "not busy after reset")
  `COM_ASSERT_RUN(busy_after_start, start && !busy |=> busy, "word start not busy")
  `COM_ASSERT_RUN(single_strobe, done |=> !done, "result strobe held")
  `COM_ASSERT_RUN(reject_zero, done && !accepted |-> cell_state == 4'd0, "rejected state")

endmodule

bind cluster_occupancy_map_top com_checker u_com_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .cell_state(cell_state), .accepted(accepted)
);
